// File: hw/rtl/fixed_chunk_free_list_pool_core_defines.svh
// Assertion macros shared by the chunk pool RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef FIXED_CHUNK_FREE_LIST_POOL_CORE_DEFINES_SVH
`define FIXED_CHUNK_FREE_LIST_POOL_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcp assertion failed");

// Next-cycle implication, disabled during reset.
`define FCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcp assertion failed");

`endif

// File: hw/rtl/fcp_pkg.sv
// Package for the fixed chunk pool: widths, status and register codes,
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcp_pkg;

   localparam int MAX_CHUNKS = 1024;
   localparam int IDX_W      = $clog2(MAX_CHUNKS);
   localparam int LINK_W     = IDX_W + 1;
   localparam int CNT_W      = LINK_W;
   localparam int ADDR_W     = 32;
   localparam int CB_W       = 17;
   localparam int CB_MAX     = 65536;
   localparam int CB_RESET   = 64;
   localparam int PROD_W     = IDX_W + CB_W;
   localparam int REGION_W   = CNT_W + CB_W;
   localparam int CMP_W      = (ADDR_W > REGION_W) ? ADDR_W : REGION_W;
   localparam int DIVC_W     = $clog2(REGION_W);
   localparam int STAT_W     = 3;
   localparam int PADDR_W    = 4;
   localparam int PDATA_W    = 32;
   localparam int RSP_FW     = ADDR_W + IDX_W + STAT_W + 2 * CNT_W;
   localparam int RSP_W      = ((RSP_FW + 7) / 8) * 8;
   localparam int REQ_W      = ((ADDR_W + 7) / 8) * 8;

   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_CHUNKS);

   localparam logic [PADDR_W-3:0] REG_BASE  = 2'd0;
   localparam logic [PADDR_W-3:0] REG_CHUNK = 2'd1;
   localparam logic [PADDR_W-3:0] REG_COUNT = 2'd2;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_NULL     = 3'd2,
      STAT_RANGE    = 3'd3,
      STAT_MISALIGN = 3'd4
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [CB_W-1:0]   cbytes;
      logic [CNT_W-1:0]  chunks;
   } cfg_type;

   typedef struct packed {
      logic clr_init;
      logic clr_step;
      logic load;
      logic alloc_empty;
      logic alloc_rd;
      logic alloc_commit;
      logic free_check;
      logic set_range;
      logic div_init;
      logic div_step;
      logic set_misalign;
      logic free_commit;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic head_none;
      logic chk_fail;
      logic range_bad;
      logic div_last;
      logic rem_nz;
      logic out_busy;
   } sts_type;

endpackage

`default_nettype wire

// File: hw/rtl/fcp_csr.sv
// Configuration registers of the chunk pool behind an APB-style port.
// Depends on fcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [fcp_pkg::PADDR_W-1:0]   csr_paddr,
   input  wire logic [fcp_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic      [fcp_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output fcp_pkg::cfg_type                   cfg,
   output logic                               cfg_wr
);

   logic [fcp_pkg::ADDR_W-1:0]  base_ff, base_in;
   logic [fcp_pkg::CB_W-1:0]    cbytes_ff, cbytes_in;
   logic [fcp_pkg::CNT_W-1:0]   chunks_ff, chunks_in;
   logic [fcp_pkg::PADDR_W-3:0] reg_idx;
   logic [fcp_pkg::CB_W-1:0]    cb_raw, cb_val;
   logic [fcp_pkg::CNT_W-1:0]   cnt_raw, cnt_val;
   logic                        wr_go;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[fcp_pkg::PADDR_W-1:2];
   assign wr_go      = csr_psel & csr_penable & csr_pwrite;
   assign cb_raw     = csr_pwdata[fcp_pkg::CB_W-1:0];
   assign cnt_raw    = csr_pwdata[fcp_pkg::CNT_W-1:0];

   always_comb begin
      if (cb_raw == '0) begin
         cb_val = fcp_pkg::CB_W'(1);
      end else if (cb_raw > fcp_pkg::CB_W'(fcp_pkg::CB_MAX)) begin
         cb_val = fcp_pkg::CB_W'(fcp_pkg::CB_MAX);
      end else begin
         cb_val = cb_raw;
      end
      if (cnt_raw == '0) begin
         cnt_val = fcp_pkg::CNT_W'(1);
      end else if (cnt_raw > fcp_pkg::CNT_W'(fcp_pkg::MAX_CHUNKS)) begin
         cnt_val = fcp_pkg::CNT_W'(fcp_pkg::MAX_CHUNKS);
      end else begin
         cnt_val = cnt_raw;
      end
   end

   always_comb begin
      base_in   = base_ff;
      cbytes_in = cbytes_ff;
      chunks_in = chunks_ff;
      cfg_wr    = 1'b0;
      if (wr_go) begin
         case (reg_idx)
            fcp_pkg::REG_BASE: begin
               base_in = csr_pwdata[fcp_pkg::ADDR_W-1:0];
               cfg_wr  = 1'b1;
            end
            fcp_pkg::REG_CHUNK: begin
               cbytes_in = cb_val;
               cfg_wr    = 1'b1;
            end
            fcp_pkg::REG_COUNT: begin
               chunks_in = cnt_val;
               cfg_wr    = 1'b1;
            end
            default: begin
               cfg_wr = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         cbytes_ff <= fcp_pkg::CB_W'(fcp_pkg::CB_RESET);
         chunks_ff <= fcp_pkg::CNT_W'(fcp_pkg::MAX_CHUNKS);
      end else begin
         base_ff   <= base_in;
         cbytes_ff <= cbytes_in;
         chunks_ff <= chunks_in;
      end
   end

   always_comb begin
      case (reg_idx)
         fcp_pkg::REG_BASE:  csr_prdata = fcp_pkg::PDATA_W'(base_ff);
         fcp_pkg::REG_CHUNK: csr_prdata = fcp_pkg::PDATA_W'(cbytes_ff);
         fcp_pkg::REG_COUNT: csr_prdata = fcp_pkg::PDATA_W'(chunks_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.base   = base_ff;
   assign cfg.cbytes = cbytes_ff;
   assign cfg.chunks = chunks_ff;

endmodule

`default_nettype wire

// File: hw/rtl/fcp_datapath.sv
// Datapath of the chunk pool: link memory, head, counters, checks, serial divider
// and the result register. Depends on fcp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_chunk_free_list_pool_core_defines.svh"

module fcp_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fcp_pkg::cfg_type             cfg,
   input  wire fcp_pkg::cmd_type             cmd,
   input  wire logic [fcp_pkg::ADDR_W-1:0]   req_addr,
   input  wire logic                         rsp_tready,
   output fcp_pkg::sts_type                  sts,
   output logic                              rsp_tvalid,
   output logic      [fcp_pkg::RSP_W-1:0]    rsp_tdata
);

   logic [fcp_pkg::LINK_W-1:0]   link_mem [fcp_pkg::MAX_CHUNKS];

   logic [fcp_pkg::IDX_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [fcp_pkg::LINK_W-1:0]   head_ff, head_in;
   logic [fcp_pkg::CNT_W-1:0]    used_ff, used_in;
   logic [fcp_pkg::CNT_W-1:0]    hw_ff, hw_in;
   logic [fcp_pkg::DIVC_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [fcp_pkg::ADDR_W-1:0]   addr_ff;
   logic [fcp_pkg::ADDR_W-1:0]   res_addr_ff;
   logic [fcp_pkg::IDX_W-1:0]    idx_ff;
   fcp_pkg::status_type          status_ff;
   logic [fcp_pkg::PROD_W-1:0]   prod_ff;
   logic [fcp_pkg::ADDR_W-1:0]   off_ff;
   logic [fcp_pkg::REGION_W-1:0] region_ff;
   logic [fcp_pkg::REGION_W-1:0] dvd_ff;
   logic [fcp_pkg::CB_W-1:0]     rem_ff;
   logic [fcp_pkg::LINK_W-1:0]   rd_ff;
   logic [fcp_pkg::RSP_W-1:0]    rsp_data_ff;

   logic [fcp_pkg::LINK_W-1:0]   clr_nxt, clr_link;
   logic [fcp_pkg::CNT_W-1:0]    used_inc, used_dec;
   logic [fcp_pkg::CB_W:0]       div_shift;
   logic                         div_ge;
   logic [fcp_pkg::IDX_W-1:0]    quo_idx;
   logic                         mem_we;
   logic [fcp_pkg::IDX_W-1:0]    mem_waddr;
   logic [fcp_pkg::LINK_W-1:0]   mem_wdata;

   assign clr_nxt  = {1'b0, clr_cnt_ff} + fcp_pkg::LINK_W'(1);
   assign clr_link = (clr_nxt < cfg.chunks) ? clr_nxt : fcp_pkg::LINK_NONE;
   assign used_inc = (used_ff < fcp_pkg::CNT_W'(fcp_pkg::MAX_CHUNKS)) ?
                     used_ff + fcp_pkg::CNT_W'(1) : used_ff;
   assign used_dec = (used_ff != '0) ? used_ff - fcp_pkg::CNT_W'(1) : used_ff;
   assign div_shift = {rem_ff, dvd_ff[fcp_pkg::REGION_W-1]};
   assign div_ge    = div_shift >= {1'b0, cfg.cbytes};
   assign quo_idx   = dvd_ff[fcp_pkg::IDX_W-1:0];

   assign sts.clr_last  = clr_cnt_ff == fcp_pkg::IDX_W'(fcp_pkg::MAX_CHUNKS - 1);
   assign sts.head_none = head_ff[fcp_pkg::LINK_W-1];
   assign sts.chk_fail  = status_ff != fcp_pkg::STAT_OK;
   assign sts.range_bad = fcp_pkg::CMP_W'(off_ff) >= fcp_pkg::CMP_W'(region_ff);
   assign sts.div_last  = div_cnt_ff == fcp_pkg::DIVC_W'(fcp_pkg::REGION_W - 1);
   assign sts.rem_nz    = rem_ff != '0;
   assign sts.out_busy  = rsp_valid_ff & ~rsp_tready;

   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      head_in      = head_ff;
      used_in      = used_ff;
      hw_in        = hw_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (cmd.clr_init) begin
         clr_cnt_in = '0;
         head_in    = '0;
         used_in    = '0;
         hw_in      = '0;
      end else begin
         if (cmd.clr_step) begin
            clr_cnt_in = clr_cnt_ff + fcp_pkg::IDX_W'(1);
         end
         if (cmd.alloc_commit) begin
            head_in = rd_ff;
            used_in = used_inc;
            hw_in   = (used_inc > hw_ff) ? used_inc : hw_ff;
         end
         if (cmd.free_commit) begin
            head_in = {1'b0, quo_idx};
            used_in = used_dec;
         end
      end
      if (cmd.div_init) begin
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff + fcp_pkg::DIVC_W'(1);
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         head_ff      <= '0;
         used_ff      <= '0;
         hw_ff        <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
         hw_ff        <= hw_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff     <= req_addr;
         res_addr_ff <= '0;
         idx_ff      <= '0;
         status_ff   <= fcp_pkg::STAT_OK;
      end
      if (cmd.alloc_empty) begin
         status_ff <= fcp_pkg::STAT_EMPTY;
      end
      if (cmd.alloc_rd) begin
         prod_ff <= fcp_pkg::PROD_W'(head_ff[fcp_pkg::IDX_W-1:0]) *
                    fcp_pkg::PROD_W'(cfg.cbytes);
         idx_ff  <= head_ff[fcp_pkg::IDX_W-1:0];
      end
      if (cmd.alloc_commit) begin
         res_addr_ff <= cfg.base + fcp_pkg::ADDR_W'(prod_ff);
      end
      if (cmd.free_check) begin
         off_ff    <= addr_ff - cfg.base;
         region_ff <= fcp_pkg::REGION_W'(cfg.chunks) * fcp_pkg::REGION_W'(cfg.cbytes);
         if (addr_ff == '0) begin
            status_ff <= fcp_pkg::STAT_NULL;
         end else if (addr_ff < cfg.base) begin
            status_ff <= fcp_pkg::STAT_RANGE;
         end
      end
      if (cmd.set_range) begin
         status_ff <= fcp_pkg::STAT_RANGE;
      end
      if (cmd.div_init) begin
         dvd_ff <= fcp_pkg::REGION_W'(off_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[fcp_pkg::REGION_W-2:0], div_ge};
         rem_ff <= div_ge ? fcp_pkg::CB_W'(div_shift - {1'b0, cfg.cbytes}) :
                            fcp_pkg::CB_W'(div_shift);
      end
      if (cmd.set_misalign) begin
         status_ff <= fcp_pkg::STAT_MISALIGN;
      end
      if (cmd.free_commit) begin
         idx_ff <= quo_idx;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= fcp_pkg::RSP_W'({hw_ff, used_ff, status_ff, idx_ff, res_addr_ff});
      end
   end

   assign mem_we    = cmd.clr_step | cmd.free_commit;
   assign mem_waddr = cmd.clr_step ? clr_cnt_ff : quo_idx;
   assign mem_wdata = cmd.clr_step ? clr_link : head_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc_rd) begin
         rd_ff <= link_mem[head_ff[fcp_pkg::IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `FCP_ASSERT_IMPLIES(a_used_bound, clock, reset, 1'b1,
                       used_ff <= fcp_pkg::CNT_W'(fcp_pkg::MAX_CHUNKS))
   `FCP_ASSERT_IMPLIES(a_watermark_covers_used, clock, reset, 1'b1, hw_ff >= used_ff)
   `FCP_ASSERT_IMPLIES(a_freed_index_in_pool, clock, reset, cmd.free_commit,
                       {1'b0, quo_idx} < cfg.chunks)

endmodule

`default_nettype wire

// File: hw/rtl/fcp_ctrl.sv
// Controller state machine of the chunk pool: sequences clearing, allocate and
// free requests and issues datapath commands. Depends on fcp_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_chunk_free_list_pool_core_defines.svh"

module fcp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cfg_wr,
   input  wire logic              req_tvalid,
   input  wire logic              req_action,
   input  wire fcp_pkg::sts_type  sts,
   output logic                   req_tready,
   output fcp_pkg::cmd_type       cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR      = 9'b000000001,
      ST_IDLE       = 9'b000000010,
      ST_ALLOC_RD   = 9'b000000100,
      ST_ALLOC_WB   = 9'b000001000,
      ST_FREE_CHK   = 9'b000010000,
      ST_FREE_RANGE = 9'b000100000,
      ST_FREE_DIV   = 9'b001000000,
      ST_FREE_PUSH  = 9'b010000000,
      ST_DONE       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = req_action ? ST_FREE_CHK : ST_ALLOC_RD;
            end
         end
         ST_ALLOC_RD: begin
            if (sts.head_none) begin
               cmd.alloc_empty = 1'b1;
               state_in        = ST_DONE;
            end else begin
               cmd.alloc_rd = 1'b1;
               state_in     = ST_ALLOC_WB;
            end
         end
         ST_ALLOC_WB: begin
            cmd.alloc_commit = 1'b1;
            state_in         = ST_DONE;
         end
         ST_FREE_CHK: begin
            cmd.free_check = 1'b1;
            state_in       = ST_FREE_RANGE;
         end
         ST_FREE_RANGE: begin
            if (sts.chk_fail) begin
               state_in = ST_DONE;
            end else if (sts.range_bad) begin
               cmd.set_range = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_FREE_DIV;
            end
         end
         ST_FREE_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FREE_PUSH;
            end
         end
         ST_FREE_PUSH: begin
            if (sts.rem_nz) begin
               cmd.set_misalign = 1'b1;
            end else begin
               cmd.free_commit = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (cfg_wr) begin
         cmd          = '0;
         cmd.clr_init = 1'b1;
         state_in     = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `FCP_ASSERT_NEXT(a_cfg_write_clears, clock, reset, cfg_wr, state_ff == ST_CLEAR)

endmodule

`default_nettype wire

// File: hw/rtl/fixed_chunk_free_list_pool_core.sv
// Top level of the fixed chunk pool allocator: configuration registers,
// controller and datapath. Depends on fcp_pkg, fcp_csr, fcp_ctrl and fcp_datapath.
//
// The pool hands out equal-sized chunks as a last-in first-out free list held in
// a 1024-entry link memory. After reset and after every configuration write the
// block runs a clearing pass that re-chains the list in ascending order; no
// request is taken during it. One request is worked at a time. An allocate
// reads the link memory and multiplies the head index by the chunk size, then
// adds the base into the result register. A free that passes its null and range
// checks runs the 28-step restoring divider that splits the offset into chunk
// index and remainder; a free that fails those checks skips it. The next request
// is accepted while the previous result still waits.
`timescale 1ns / 1ps
`default_nettype none

module fixed_chunk_free_list_pool_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // Bits 31:0 free_address.
   input  wire logic [fcp_pkg::REQ_W-1:0]   req_tdata,
   // Bit 0 action.
   input  wire logic                        req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // Bits 31:0 chunk_address, 41:32 chunk_index, 44:42 status,
   // 55:45 used_chunks, 66:56 watermark_chunks, 71:67 zero.
   output logic      [fcp_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [fcp_pkg::PADDR_W-1:0] csr_paddr,
   input  wire logic [fcp_pkg::PDATA_W-1:0] csr_pwdata,
   output logic      [fcp_pkg::PDATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);

   fcp_pkg::cfg_type cfg;
   fcp_pkg::cmd_type cmd;
   fcp_pkg::sts_type sts;
   logic             cfg_wr;

   fcp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_wr      (cfg_wr)
   );

   fcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg_wr     (cfg_wr),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   fcp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .req_addr   (req_tdata[fcp_pkg::ADDR_W-1:0]),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
